// ===== rtl/asc_pkg.sv =====
package asc_pkg;

	localparam int unsigned WORD_W       = 64;
	localparam int unsigned LANES        = 5;
	localparam int unsigned CNT_W        = 4;
	localparam int unsigned RND_W        = 4;
	localparam int unsigned IN_TDATA_W   = 136;
	localparam int unsigned OUT_TDATA_W  = 200;
	localparam int unsigned IN_TUSER_W   = 3;
	localparam int unsigned OUT_TUSER_W  = 3;
	localparam int unsigned CFG_IDX_W    = 1;

	localparam logic [WORD_W-1:0] ASC_IV = 64'h80400c0600000000;
	localparam logic [CNT_W-1:0]  FULL_BYTES = 4'd8;
	localparam logic [RND_W-1:0]  RND_FIRST_A = 4'd0;
	localparam logic [RND_W-1:0]  RND_FIRST_B = 4'd6;
	localparam logic [RND_W-1:0]  RND_LAST = 4'd11;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'd1;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_AD    = 2'd1,
		MODE_TEXT  = 2'd2,
		MODE_TAG   = 2'd3
	} mode_t;

	typedef logic [LANES-1:0][WORD_W-1:0] lanes_t;

	typedef struct packed {
		logic [WORD_W-1:0] tag_low;
		logic [WORD_W-1:0] tag_high;
		logic [CNT_W-1:0]  out_bytes;
		logic [WORD_W-1:0] out_data;
		logic              status;
		logic              auth_ok;
		logic              tag_valid;
	} res_t;

	localparam logic [7:0] ASC_RC [12] = '{
		8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
		8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
	};

	function automatic logic [WORD_W-1:0] lead_mask(input logic [CNT_W-1:0] n);
		logic [6:0] sh;
		sh = 7'd64 - {n, 3'b000};
		return ~64'd0 << sh;
	endfunction

	function automatic logic [WORD_W-1:0] pad_bit(input logic [CNT_W-1:0] n);
		logic [6:0] sh;
		sh = 7'd56 - {n, 3'b000};
		return 64'h80 << sh;
	endfunction

endpackage

// ===== rtl/ascon128_aead_top.sv =====
// Rounds per accepted beat: a start item or a final text block runs 12 rounds, an associated-data
// or full text block runs 6 rounds, and a tag check or an ignored item runs none. All rounds run on
// the single round unit, one round a cycle; no new beat is taken until the last result has moved on.
// Reset (arst_n low, asynchronous) clears the key, the state lanes, the phase and the output register.
module ascon128_aead_top import asc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [WORD_W-1:0]       cfg_data,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// data_high, data_low, byte_count, zero fill
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	// mode, decrypt
	input  logic [IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// out_data, out_bytes, tag_high, tag_low, zero fill
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
	// tag_valid, auth_ok, status
	output logic [OUT_TUSER_W-1:0]  m_axis_tuser
);

	res_t res, out_q;
	logic res_valid, res_ready, out_valid_q;

	asc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_mode       (mode_t'(s_axis_tuser[1:0])),
		.in_decrypt    (s_axis_tuser[2]),
		.in_data_high  (s_axis_tdata[63:0]),
		.in_data_low   (s_axis_tdata[127:64]),
		.in_byte_count (s_axis_tdata[131:128]),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (res_ready) begin
				out_valid_q <= res_valid;
				if (res_valid) begin
					out_q <= res;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.tag_low, out_q.tag_high, out_q.out_bytes, out_q.out_data};
	assign m_axis_tuser  = {out_q.status, out_q.auth_ok, out_q.tag_valid};

endmodule

// ===== rtl/asc_round.sv =====
module asc_round import asc_pkg::*; (
	input  lanes_t           lanes_in,
	input  logic [RND_W-1:0] rnd,
	output lanes_t           lanes_out
);

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	logic [WORD_W-1:0] a, b, c, d, e;
	logic [WORD_W-1:0] a1, b1, c1, d1, e1;
	logic [WORD_W-1:0] a2, b2, c2, d2, e2;

	always_comb begin
		a = lanes_in[0];
		b = lanes_in[1];
		c = lanes_in[2] ^ {56'd0, ASC_RC[rnd]};
		d = lanes_in[3];
		e = lanes_in[4];
		a = a ^ e;
		e = e ^ d;
		c = c ^ b;
		a1 = a ^ (~b & c);
		b1 = b ^ (~c & d);
		c1 = c ^ (~d & e);
		d1 = d ^ (~e & a);
		e1 = e ^ (~a & b);
		b1 = b1 ^ a1;
		a1 = a1 ^ e1;
		d1 = d1 ^ c1;
		c1 = ~c1;
		a2 = a1 ^ rotr(a1, 19) ^ rotr(a1, 28);
		b2 = b1 ^ rotr(b1, 61) ^ rotr(b1, 39);
		c2 = c1 ^ rotr(c1, 1) ^ rotr(c1, 6);
		d2 = d1 ^ rotr(d1, 10) ^ rotr(d1, 17);
		e2 = e1 ^ rotr(e1, 7) ^ rotr(e1, 41);
		lanes_out = {e2, d2, c2, b2, a2};
	end

endmodule

// ===== rtl/asc_core.sv =====
module asc_core import asc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mode_t                 in_mode,
	input  logic                  in_decrypt,
	input  logic [WORD_W-1:0]     in_data_high,
	input  logic [WORD_W-1:0]     in_data_low,
	input  logic [CNT_W-1:0]      in_byte_count,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;
	typedef enum logic [1:0] {PH_IDLE, PH_AD, PH_TEXT, PH_DONE} phase_t;
	typedef enum logic [1:0] {POST_NONE, POST_KEY, POST_DSEP, POST_TAG} post_t;

	state_t            state_q;
	phase_t            phase_q, pre_phase;
	post_t             post_q, pre_post;
	lanes_t            lane_q, pre_lanes, rnd_out, post_lanes;
	res_t              res_q, pre_res;
	logic [RND_W-1:0]  round_q, pre_round;
	logic [WORD_W-1:0] key_high_q, key_low_q;
	logic              decrypting_q, dsd_q, pre_dec, pre_dsd, pre_run;
	logic [CNT_W-1:0]  n;
	logic [WORD_W-1:0] m, blk, pad;
	logic              accept;

	asc_round u_round (
		.lanes_in  (lane_q),
		.rnd       (round_q),
		.lanes_out (rnd_out)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_HOLD);
	assign res       = res_q;

	always_comb begin
		n = (in_byte_count > FULL_BYTES) ? FULL_BYTES : in_byte_count;
		m = lead_mask(n);
		pad = (n < FULL_BYTES) ? pad_bit(n) : '0;
		blk = in_data_high & m;
		pre_lanes = lane_q;
		pre_res = '0;
		pre_round = RND_FIRST_B;
		pre_run = 1'b0;
		pre_post = POST_NONE;
		pre_phase = phase_q;
		pre_dec = decrypting_q;
		pre_dsd = dsd_q;
		unique case (in_mode)
			MODE_START: begin
				pre_lanes = {in_data_low, in_data_high, key_low_q, key_high_q, ASC_IV};
				pre_dec = in_decrypt;
				pre_dsd = 1'b0;
				pre_phase = PH_AD;
				pre_round = RND_FIRST_A;
				pre_run = 1'b1;
				pre_post = POST_KEY;
			end
			MODE_AD: begin
				if (phase_q != PH_AD) begin
					pre_res.status = 1'b1;
				end else begin
					pre_lanes[0] = lane_q[0] ^ blk ^ pad;
					pre_run = 1'b1;
					if (n < FULL_BYTES) begin
						pre_post = POST_DSEP;
						pre_dsd = 1'b1;
						pre_phase = PH_TEXT;
					end
				end
			end
			MODE_TEXT: begin
				if (phase_q != PH_AD && phase_q != PH_TEXT) begin
					pre_res.status = 1'b1;
				end else begin
					pre_lanes[4][0] = lane_q[4][0] ^ ~dsd_q;
					pre_dsd = 1'b1;
					pre_phase = PH_TEXT;
					pre_res.out_data = (lane_q[0] ^ blk) & m;
					if (decrypting_q) begin
						pre_lanes[0] = (lane_q[0] & ~m) | blk;
					end else begin
						pre_lanes[0] = lane_q[0] ^ blk;
					end
					pre_res.out_bytes = n;
					pre_run = 1'b1;
					if (n < FULL_BYTES) begin
						pre_lanes[0] = pre_lanes[0] ^ pad;
						pre_lanes[1] = lane_q[1] ^ key_high_q;
						pre_lanes[2] = lane_q[2] ^ key_low_q;
						pre_round = RND_FIRST_A;
						pre_post = POST_TAG;
						pre_phase = PH_DONE;
					end
				end
			end
			MODE_TAG: begin
				if (phase_q != PH_DONE) begin
					pre_res.status = 1'b1;
				end else begin
					pre_res.auth_ok = (lane_q[3] == in_data_high) && (lane_q[4] == in_data_low);
				end
			end
		endcase
	end

	always_comb begin
		post_lanes = rnd_out;
		if (round_q == RND_LAST) begin
			unique case (post_q)
				POST_NONE: ;
				POST_DSEP: post_lanes[4][0] = ~rnd_out[4][0];
				POST_KEY, POST_TAG: begin
					post_lanes[3] = rnd_out[3] ^ key_high_q;
					post_lanes[4] = rnd_out[4] ^ key_low_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			post_q <= POST_NONE;
			round_q <= '0;
			decrypting_q <= 1'b0;
			dsd_q <= 1'b0;
			key_high_q <= '0;
			key_low_q <= '0;
			lane_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW:  key_low_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lane_q <= pre_lanes;
						res_q <= pre_res;
						round_q <= pre_round;
						post_q <= pre_post;
						phase_q <= pre_phase;
						decrypting_q <= pre_dec;
						dsd_q <= pre_dsd;
						state_q <= pre_run ? ST_RUN : ST_HOLD;
					end
				end
				ST_RUN: begin
					lane_q <= post_lanes;
					if (round_q == RND_LAST) begin
						round_q <= '0;
						state_q <= ST_HOLD;
						if (post_q == POST_TAG) begin
							res_q.tag_high <= post_lanes[3];
							res_q.tag_low <= post_lanes[4];
							res_q.tag_valid <= 1'b1;
						end
					end else begin
						round_q <= round_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/asc_checker.sv =====
module asc_props import asc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still ready after an accepted beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result beat changed");

	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0 && m_axis_tuser[1:0] == 2'd0)
		else $error("ignored item carries result fields");

	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[195:68] == '0)
		else $error("tag fields set without tag_valid");

	a_ok_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[67:0] == '0 && !m_axis_tuser[0])
		else $error("tag check result mixed with text or tag");

endmodule

bind ascon128_aead_top asc_props u_asc_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
